>>> hw/rtl/sfd_pkg.sv
// Shared types and constants for the SBUS frame decoder.
package sfd_pkg;

  localparam int FRAME_BYTES  = 25;
  localparam int STORE_DEPTH  = FRAME_BYTES - 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CHAN_W       = 11;
  localparam int MAX_CHANNELS = 16;
  localparam int IDX_W        = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = IDX_W + 1;
  // bit accumulator: up to 10 leftover bits plus one new byte
  localparam int ACC_W        = CHAN_W - 1 + 8;
  localparam int ACC_CNT_W    = $clog2(ACC_W + 1);

  localparam logic [7:0]        START_BYTE  = 8'h0F;
  localparam logic [7:0]        END_BYTE    = 8'h00;
  localparam logic [ADDR_W-1:0] FLAG_POS    = ADDR_W'(23);
  localparam int                FLAG_LOST_BIT     = 2;
  localparam int                FLAG_FAILSAFE_BIT = 3;
  localparam logic [CNT_W-1:0]  DEFAULT_CH_COUNT  = CNT_W'(10);

  typedef logic [1:0] link_status_t;
  localparam link_status_t LINK_OK       = 2'd0;
  localparam link_status_t LINK_LOST     = 2'd1;
  localparam link_status_t LINK_FAILSAFE = 2'd2;

  typedef logic [ADDR_W-1:0] store_addr_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] chan_count;  // already limited to 1..16
  } unpack_req_t;

endpackage

>>> hw/rtl/sfd_frame_ram.sv
// Frame byte store: one write port, one registered read port.
module sfd_frame_ram (
  input  logic               clk,
  input  logic               wr_en,
  input  sfd_pkg::store_addr_t wr_addr,
  input  logic [7:0]         wr_data,
  input  logic               rd_en,
  input  sfd_pkg::store_addr_t rd_addr,
  output logic [7:0]         rd_data
);
  import sfd_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/sfd_unpack.sv
// Channel unpacker: walks the stored frame byte by byte and emits 11-bit channels.
module sfd_unpack (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfd_pkg::unpack_req_t  req,
  output logic                  busy,
  output logic                  rd_en,
  output sfd_pkg::store_addr_t  rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_channel_index,
  output logic [10:0]           out_channel_value,
  output logic [1:0]            out_link_status,
  output logic                  out_last_channel
);
  import sfd_pkg::*;

  localparam logic [2:0] U_IDLE  = 3'd0;
  localparam logic [2:0] U_FLAG  = 3'd1;  // read request for flag byte
  localparam logic [2:0] U_FLAGD = 3'd2;  // flag byte on read data
  localparam logic [2:0] U_RD    = 3'd3;
  localparam logic [2:0] U_ACC   = 3'd4;
  localparam logic [2:0] U_EMIT  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [IDX_W-1:0]     ch_r, ch_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ACC_CNT_W-1:0] cnt_r, cnt_nxt;
  store_addr_t          addr_r, addr_nxt;
  link_status_t         status_r, status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [CHAN_W-1:0]    out_val_r, out_val_nxt;
  link_status_t         out_stat_r, out_stat_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 slot_free;
  logic                 emit;
  logic                 is_last;
  logic [ACC_CNT_W-1:0] cnt_add;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (state_r == U_EMIT) && slot_free;
  assign is_last   = (CNT_W'(ch_r) + CNT_W'(1)) == n_r;
  assign cnt_add   = cnt_r + ACC_CNT_W'(8);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    ch_nxt        = ch_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    status_nxt    = status_r;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      U_IDLE: begin
        if (req.start) begin
          n_nxt     = req.chan_count;
          state_nxt = U_FLAG;
        end
      end
      U_FLAG: begin
        rd_en     = 1'b1;
        rd_addr   = FLAG_POS;
        state_nxt = U_FLAGD;
      end
      U_FLAGD: begin
        if (rd_data[FLAG_LOST_BIT]) begin
          status_nxt = LINK_LOST;
        end else if (rd_data[FLAG_FAILSAFE_BIT]) begin
          status_nxt = LINK_FAILSAFE;
        end else begin
          status_nxt = LINK_OK;
        end
        acc_nxt   = '0;
        cnt_nxt   = '0;
        ch_nxt    = '0;
        addr_nxt  = store_addr_t'(1);
        state_nxt = U_RD;
      end
      U_RD: begin
        rd_en     = 1'b1;
        state_nxt = U_ACC;
      end
      U_ACC: begin
        acc_nxt   = acc_r | (ACC_W'(rd_data) << cnt_r);
        cnt_nxt   = cnt_add;
        addr_nxt  = addr_r + store_addr_t'(1);
        state_nxt = (cnt_add >= ACC_CNT_W'(CHAN_W)) ? U_EMIT : U_RD;
      end
      U_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = ch_r;
          out_val_nxt   = acc_r[CHAN_W-1:0];
          out_stat_nxt  = status_r;
          out_last_nxt  = is_last;
          acc_nxt       = acc_r >> CHAN_W;
          cnt_nxt       = cnt_r - ACC_CNT_W'(CHAN_W);
          ch_nxt        = ch_r + IDX_W'(1);
          state_nxt     = is_last ? U_IDLE : U_RD;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= U_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    ch_r       <= ch_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    status_r   <= status_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy              = (state_r != U_IDLE);
  assign out_valid         = out_valid_r;
  assign out_channel_index = out_idx_r;
  assign out_channel_value = out_val_r;
  assign out_link_status   = out_stat_r;
  assign out_last_channel  = out_last_r;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (state_r == U_IDLE))
    else $error("unpack request while busy");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_ACC || state_r == U_EMIT || state_r == U_RD)
      |-> (cnt_r <= ACC_CNT_W'(ACC_W)))
    else $error("bit accumulator overflow");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_addr < store_addr_t'(STORE_DEPTH)))
    else $error("frame store read out of range");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> (state_r == U_IDLE && out_valid_r && out_last_r))
    else $error("last channel did not end the frame");

endmodule

>>> hw/rtl/sbus_frame_decoder.sv
// Top level of the SBUS frame decoder: byte receiver, frame store and unpacker.
//
// Bytes are taken one per cycle while a frame is being collected; each one but the
// closing byte is written into a 24-byte frame RAM. When the closing byte of a valid
// frame (0x00) is taken, in_ready drops while the unpacker reads the flag byte and then
// the channel bytes through the RAM's single read port; a stall on the output side
// keeps it low. Results come out one channel per request, channel 0 first, with
// last_channel set on the final one. Configuration writes are taken at any time
// without wait; channel_count is limited to the range 1..16.
module sbus_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel_index,
  output logic [10:0] out_channel_value,
  output logic [1:0]  out_link_status,
  output logic        out_last_channel
);
  import sfd_pkg::*;

  logic             receiving_r, receiving_nxt;
  logic [4:0]       byte_pos_r, byte_pos_nxt;
  logic [4:0]       chan_cfg_r;
  logic [4:0]       pos_inc;
  logic             in_acc;
  logic             wr_en;
  store_addr_t      wr_addr;
  logic [CNT_W-1:0] chan_sat;
  unpack_req_t      req;
  logic             busy;
  logic             rd_en;
  store_addr_t      rd_addr;
  logic [7:0]       rd_data;

  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  assign pos_inc  = byte_pos_r + 5'd1;

  always_comb begin
    if (chan_cfg_r == 5'd0) begin
      chan_sat = CNT_W'(1);
    end else if (chan_cfg_r > 5'(MAX_CHANNELS)) begin
      chan_sat = CNT_W'(MAX_CHANNELS);
    end else begin
      chan_sat = CNT_W'(chan_cfg_r);
    end
  end

  always_comb begin
    receiving_nxt  = receiving_r;
    byte_pos_nxt   = byte_pos_r;
    wr_en          = 1'b0;
    wr_addr        = store_addr_t'(pos_inc);
    req.start      = 1'b0;
    req.chan_count = chan_sat;
    if (in_acc) begin
      if (!receiving_r) begin
        if (in_rx_byte == START_BYTE) begin
          receiving_nxt = 1'b1;
          byte_pos_nxt  = 5'd0;
          wr_en         = 1'b1;
          wr_addr       = '0;
        end
      end else if (pos_inc < 5'(STORE_DEPTH)) begin
        byte_pos_nxt = pos_inc;
        wr_en        = 1'b1;
      end else begin
        // closing byte: frame is good only if it is the end marker
        receiving_nxt = 1'b0;
        byte_pos_nxt  = pos_inc;
        req.start     = (in_rx_byte == END_BYTE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      byte_pos_r  <= 5'd0;
      chan_cfg_r  <= 5'(DEFAULT_CH_COUNT);
    end else begin
      receiving_r <= receiving_nxt;
      byte_pos_r  <= byte_pos_nxt;
      if (cfg_wr_en) begin
        chan_cfg_r <= cfg_wr_data;
      end
    end
  end

  sfd_frame_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfd_unpack u_unpack (
    .clk               (clk),
    .rst_n             (rst_n),
    .req               (req),
    .busy              (busy),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_link_status   (out_link_status),
    .out_last_channel  (out_last_channel)
  );

endmodule

>>> verif/sbus_frame_decoder_tb.sv
// Self-checking testbench for sbus_frame_decoder: byte stream in, per-channel results out.
module sbus_frame_decoder_tb;
  import sfd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 10;

  typedef logic [7:0] payload_t [22];

  typedef struct {
    logic [3:0]   index;
    logic [10:0]  value;
    link_status_t status;
    logic         last;
  } chan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_channel_index;
  logic [10:0] out_channel_value;
  logic [1:0]  out_link_status;
  logic        out_last_channel;

  // predictor state
  logic       rx_active = 1'b0;
  logic [4:0] rx_pos = '0;
  logic [7:0] frame_bytes [STORE_DEPTH];
  logic [4:0] chan_cfg = DEFAULT_CH_COUNT;

  chan_result_t expected_channels [$];
  int fail_count = 0;
  int useful_items = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  sbus_frame_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_link_status   (out_link_status),
    .out_last_channel  (out_last_channel)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void predict_byte(input logic [7:0] b);
    int n;
    int bitpos;
    int p;
    logic [23:0] win;
    link_status_t st;
    chan_result_t r;
    if (!rx_active) begin
      if (b == START_BYTE) begin
        rx_active = 1'b1;
        rx_pos = '0;
        frame_bytes[0] = b;
        useful_items++;
      end
      return;
    end
    useful_items++;
    rx_pos = rx_pos + 5'd1;
    if (rx_pos < STORE_DEPTH) begin
      frame_bytes[rx_pos] = b;
      return;
    end
    rx_active = 1'b0;
    if (b != END_BYTE) return;
    if (frame_bytes[FLAG_POS][FLAG_LOST_BIT]) st = LINK_LOST;
    else if (frame_bytes[FLAG_POS][FLAG_FAILSAFE_BIT]) st = LINK_FAILSAFE;
    else st = LINK_OK;
    n = (chan_cfg == 0) ? 1 : (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_cfg);
    for (int ch = 0; ch < n; ch++) begin
      bitpos = ch * CHAN_W;
      p = 1 + bitpos / 8;
      // channels are packed LSB-first; a channel spans at most three bytes
      win = {frame_bytes[p + 2], frame_bytes[p + 1], frame_bytes[p]};
      r.index = 4'(ch);
      r.value = 11'(win >> (bitpos % 8));
      r.status = st;
      r.last = (ch + 1 == n);
      expected_channels.push_back(r);
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame(input payload_t pl, input logic [7:0] flags,
                            input logic [7:0] closing);
    send_byte(START_BYTE);
    for (int i = 0; i < 22; i++) send_byte(pl[i]);
    send_byte(flags);
    send_byte(closing);
  endtask

  task automatic send_random_frame(input int good_pct);
    payload_t pl;
    logic [7:0] closing;
    for (int i = 0; i < 22; i++)
      pl[i] = ($urandom_range(9) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
    closing = ($urandom_range(99) < good_pct) ? END_BYTE : 8'($urandom_range(1, 255));
    send_frame(pl, 8'($urandom_range(0, 255)), closing);
  endtask

  // close any open frame, hold requests off until all results are back
  task automatic settle();
    while (rx_active) send_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;
    while (expected_channels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_channel_count(input logic [4:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    chan_cfg = v;
  endtask

  task automatic test_idle_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hF0);
    send_byte(8'h0E);
  endtask

  task automatic test_frame_extremes();
    payload_t pl;
    for (int i = 0; i < 22; i++) pl[i] = 8'hFF;
    pl[5] = START_BYTE;  // start byte mid-frame is plain data
    send_frame(pl, 8'h0C, END_BYTE);  // lost wins over failsafe
    for (int i = 0; i < 22; i++) pl[i] = 8'h00;
    send_frame(pl, 8'h08, END_BYTE);
    for (int i = 0; i < 22; i++) pl[i] = 8'($urandom_range(0, 255));
    send_frame(pl, 8'hF3, END_BYTE);
  endtask

  task automatic test_bad_closing_byte();
    payload_t pl;
    for (int i = 0; i < 22; i++) pl[i] = 8'($urandom_range(0, 255));
    send_frame(pl, 8'h04, 8'h80);
    send_frame(pl, 8'h00, 8'h01);
    send_frame(pl, 8'h00, END_BYTE);
  endtask

  task automatic test_channel_counts();
    logic [4:0] counts [5] = '{5'd16, 5'd1, 5'd0, 5'd17, 5'd31};
    send_idle_pct = 30;
    recv_stall_pct = 30;
    foreach (counts[i]) begin
      settle();
      write_channel_count(counts[i]);
      send_random_frame(100);
    end
  endtask

  task automatic test_random_traffic();
    int start_items;
    int idle_tab [4] = '{0, 70, 0, 20};
    int stall_tab [4] = '{0, 0, 70, 20};
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      write_channel_count(5'($urandom_range(0, 31)));
      start_items = useful_items;
      while (useful_items - start_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) send_random_frame(85);
        else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    chan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_channels.size() == 0) begin
        $error("unexpected channel result: index %0d value %0d",
               out_channel_index, out_channel_value);
        fail_count++;
      end else begin
        want = expected_channels.pop_front();
        if (out_channel_index !== want.index) begin
          $error("channel_index: expected %0d, got %0d", want.index, out_channel_index);
          fail_count++;
        end
        if (out_channel_value !== want.value) begin
          $error("channel_value: expected %0d, got %0d", want.value, out_channel_value);
          fail_count++;
        end
        if (out_link_status !== want.status) begin
          $error("link_status: expected %0d, got %0d", want.status, out_link_status);
          fail_count++;
        end
        if (out_last_channel !== want.last) begin
          $error("last_channel: expected %0d, got %0d", want.last, out_last_channel);
          fail_count++;
        end
      end
    end
  end

  // no request moving on either side for too long means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_noise();
    test_frame_extremes();
    test_bad_closing_byte();
    test_channel_counts();
    test_random_traffic();
    settle();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
